// ===== rtl/lca_pkg.sv =====
`timescale 1ns / 1ps
package lca_pkg;

  localparam int unsigned MAX_NODES = 1023;
  localparam int unsigned LEVELS    = 10;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned NODES     = MAX_NODES + 1;
  localparam int unsigned ADDR_W    = $clog2(NODES);
  localparam logic [NODE_W-1:0] OUT_MAX = NODE_W'(1023);

  // request kinds
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_BUILD = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_ACCEPT,
    OP_LOAD,
    OP_B_INIT,
    OP_B_RD_X,
    OP_B_RD_PAR,
    OP_B_WR,
    OP_D_INIT,
    OP_RD_A,
    OP_D_STEP,
    OP_Q_RD_DA,
    OP_Q_RD_DB,
    OP_Q_SET,
    OP_Q_LSTEP,
    OP_Q_CMP,
    OP_RD_AB,
    OP_Q_TSTEP,
    OP_Q_PAR,
    OP_Q_RD_DC,
    OP_Q_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } lca_cmd_t;

  typedef struct packed {
    logic x_last;
    logic x_ge_hi;
    logic hi_zero;
    logic lvl_last;
    logic lvl_zero;
    logic a_eq_b;
    logic out_busy;
  } lca_sts_t;

  // ids above the table range stand for node 0
  function automatic logic [NODE_W-1:0] node_id(input logic [NODE_W-1:0] v);
    node_id = ({22'd0, v} <= 32'(MAX_NODES)) ? v : '0;
  endfunction

endpackage

// ===== rtl/lca_ctrl.sv =====
`timescale 1ns / 1ps
module lca_ctrl import lca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  output logic       in_ready_o,
  output lca_cmd_t   cmd_o,
  input  lca_sts_t   sts_i
);

  typedef enum logic [4:0] {
    ST_CLR_INIT, ST_CLR, ST_IDLE, ST_LOAD,
    ST_B_INIT, ST_B_RD1, ST_B_RD2, ST_B_WR,
    ST_D_INIT, ST_D_RD, ST_D_STEP,
    ST_Q_RDA, ST_Q_RDB, ST_Q_SET, ST_Q_LRD, ST_Q_LSTEP, ST_Q_CMP,
    ST_Q_TRD, ST_Q_TSTEP, ST_Q_PRD, ST_Q_PAR, ST_Q_RDC, ST_Q_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_CLR_INIT: begin
        cmd_o.op = OP_CLR_INIT;
        state_d  = ST_CLR;
      end
      ST_CLR: begin
        cmd_o.op = OP_CLR_STEP;
        if (sts_i.x_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          case (req_type_i)
            REQ_CLEAR: state_d = ST_CLR_INIT;
            REQ_LOAD:  state_d = ST_LOAD;
            REQ_BUILD: state_d = ST_B_INIT;
            default:   state_d = ST_Q_RDA;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = ST_IDLE;
      end
      ST_B_INIT: begin
        cmd_o.op = OP_B_INIT;
        state_d  = sts_i.hi_zero ? ST_IDLE : ST_B_RD1;
      end
      ST_B_RD1: begin
        cmd_o.op = OP_B_RD_X;
        state_d  = ST_B_RD2;
      end
      ST_B_RD2: begin
        cmd_o.op = OP_B_RD_PAR;
        state_d  = ST_B_WR;
      end
      ST_B_WR: begin
        cmd_o.op = OP_B_WR;
        state_d  = (sts_i.x_ge_hi && sts_i.lvl_last) ? ST_D_INIT : ST_B_RD1;
      end
      ST_D_INIT: begin
        cmd_o.op = OP_D_INIT;
        state_d  = ST_D_RD;
      end
      ST_D_RD: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_D_STEP;
      end
      ST_D_STEP: begin
        cmd_o.op = OP_D_STEP;
        state_d  = (sts_i.lvl_zero && sts_i.x_ge_hi) ? ST_IDLE : ST_D_RD;
      end
      ST_Q_RDA: begin
        cmd_o.op = OP_Q_RD_DA;
        state_d  = ST_Q_RDB;
      end
      ST_Q_RDB: begin
        cmd_o.op = OP_Q_RD_DB;
        state_d  = ST_Q_SET;
      end
      ST_Q_SET: begin
        cmd_o.op = OP_Q_SET;
        state_d  = ST_Q_LRD;
      end
      ST_Q_LRD: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_Q_LSTEP;
      end
      ST_Q_LSTEP: begin
        cmd_o.op = OP_Q_LSTEP;
        state_d  = sts_i.lvl_last ? ST_Q_CMP : ST_Q_LRD;
      end
      ST_Q_CMP: begin
        cmd_o.op = OP_Q_CMP;
        state_d  = sts_i.a_eq_b ? ST_Q_RDC : ST_Q_TRD;
      end
      ST_Q_TRD: begin
        cmd_o.op = OP_RD_AB;
        state_d  = ST_Q_TSTEP;
      end
      ST_Q_TSTEP: begin
        cmd_o.op = OP_Q_TSTEP;
        state_d  = sts_i.lvl_zero ? ST_Q_PRD : ST_Q_TRD;
      end
      ST_Q_PRD: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_Q_PAR;
      end
      ST_Q_PAR: begin
        cmd_o.op = OP_Q_PAR;
        state_d  = ST_Q_RDC;
      end
      ST_Q_RDC: begin
        cmd_o.op = OP_Q_RD_DC;
        state_d  = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_Q_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLR_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/lca_dpath.sv =====
`timescale 1ns / 1ps
module lca_dpath import lca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lca_cmd_t          cmd_i,
  output lca_sts_t          sts_o,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NODE_W-1:0] ancestor_o,
  output logic [NODE_W-1:0] ancestor_depth_o,
  output logic [NODE_W-1:0] step_count_o
);

  typedef logic [LEVELS-1:0][NODE_W-1:0] row_t;

  // ancestor rows (one lane per level) and depths
  row_t              jump_mem [NODES];
  logic [NODE_W-1:0] depth_mem [NODES];

  row_t              row_a_q, row_b_q;
  logic [NODE_W-1:0] dd_q;

  logic [NODE_W-1:0] na_q, nb_q, a_q, a_d, b_q, b_d, c_q, c_d;
  logic [NODE_W-1:0] x_q, x_d, hi_q, hi_d, d_q, d_d, da_q, da_d, diff_q, diff_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] anc_q, anc_d, adep_q, adep_d, steps_q, steps_d;

  // memory port selection
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, drd_addr;
  logic              rd_a_en, rd_b_en, drd_en;
  logic [NODE_W-1:0] par, wk, d_new, dc_diff;
  logic [NODE_W:0]   steps_sum;

  assign par   = row_a_q[lvl_q - LVL_W'(1)];
  assign wk    = row_a_q[lvl_q];
  assign d_new = (wk != '0) ? (d_q | (NODE_W'(1) << lvl_q)) : d_q;

  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    drd_en    = 1'b0;
    rd_a_addr = ADDR_W'(a_q);
    rd_b_addr = ADDR_W'(b_q);
    drd_addr  = ADDR_W'(na_q);
    case (cmd_i.op)
      OP_B_RD_X: begin
        rd_a_en   = 1'b1;
        rd_a_addr = ADDR_W'(x_q);
      end
      OP_B_RD_PAR: begin
        rd_a_en   = 1'b1;
        rd_a_addr = ADDR_W'(par);
      end
      OP_RD_A: rd_a_en = 1'b1;
      OP_RD_AB: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
      end
      OP_Q_RD_DA: drd_en = 1'b1;
      OP_Q_RD_DB: begin
        drd_en   = 1'b1;
        drd_addr = ADDR_W'(nb_q);
      end
      OP_Q_RD_DC: begin
        drd_en   = 1'b1;
        drd_addr = ADDR_W'(c_q);
      end
      default: ;
    endcase
  end

  // memories: registered reads, one write per table per cycle
  always_ff @(posedge clk_i) begin
    if (rd_a_en) row_a_q <= jump_mem[rd_a_addr];
    if (rd_b_en) row_b_q <= jump_mem[rd_b_addr];
    if (drd_en)  dd_q    <= depth_mem[drd_addr];
    case (cmd_i.op)
      OP_CLR_STEP: begin
        jump_mem[ADDR_W'(x_q)]  <= '0;
        depth_mem[ADDR_W'(x_q)] <= '0;
      end
      OP_LOAD: begin
        if (na_q != '0) jump_mem[ADDR_W'(na_q)][0] <= nb_q;
      end
      OP_B_WR: jump_mem[ADDR_W'(x_q)][lvl_q] <= par;
      OP_D_STEP: begin
        if (lvl_q == '0) depth_mem[ADDR_W'(x_q)] <= d_new;
      end
      default: ;
    endcase
  end

  // step count: depth difference clamped at zero, plus one off the b side
  assign dc_diff   = (da_q > dd_q) ? (da_q - dd_q) : '0;
  assign steps_sum = {1'b0, dc_diff} + {{NODE_W{1'b0}}, (c_q != nb_q)};

  // register updates per operation
  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; x_d = x_q; hi_d = hi_q; d_d = d_q;
    da_d = da_q; diff_d = diff_q; lvl_d = lvl_q;
    anc_d = anc_q; adep_d = adep_q; steps_d = steps_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      OP_CLR_INIT: begin
        x_d  = '0;
        hi_d = '0;
      end
      OP_CLR_STEP: x_d = x_q + NODE_W'(1);
      OP_LOAD: begin
        if (na_q != '0) begin
          if (na_q > hi_d) hi_d = na_q;
          if (nb_q > hi_d) hi_d = nb_q;
        end
      end
      OP_B_INIT: begin
        x_d   = NODE_W'(1);
        lvl_d = LVL_W'(1);
      end
      OP_B_WR: begin
        if (x_q >= hi_q) begin
          x_d   = NODE_W'(1);
          lvl_d = lvl_q + LVL_W'(1);
        end else begin
          x_d = x_q + NODE_W'(1);
        end
      end
      OP_D_INIT: begin
        x_d   = NODE_W'(1);
        a_d   = NODE_W'(1);
        d_d   = '0;
        lvl_d = LVL_W'(LEVELS - 1);
      end
      OP_D_STEP: begin
        if (wk != '0) a_d = wk;
        d_d = d_new;
        if (lvl_q == '0) begin
          x_d   = x_q + NODE_W'(1);
          a_d   = x_q + NODE_W'(1);
          d_d   = '0;
          lvl_d = LVL_W'(LEVELS - 1);
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      OP_Q_RD_DB: da_d = dd_q;
      OP_Q_SET: begin
        lvl_d = '0;
        if (da_q < dd_q) begin
          a_d    = nb_q;
          b_d    = na_q;
          diff_d = dd_q - da_q;
        end else begin
          a_d    = na_q;
          b_d    = nb_q;
          diff_d = da_q - dd_q;
        end
      end
      OP_Q_LSTEP: begin
        if (diff_q[lvl_q]) a_d = wk;
        lvl_d = lvl_q + LVL_W'(1);
      end
      OP_Q_CMP: begin
        c_d   = a_q;
        lvl_d = LVL_W'(LEVELS - 1);
      end
      OP_Q_TSTEP: begin
        if (row_a_q[lvl_q] != row_b_q[lvl_q]) begin
          a_d = row_a_q[lvl_q];
          b_d = row_b_q[lvl_q];
        end
        if (lvl_q != '0) lvl_d = lvl_q - LVL_W'(1);
      end
      OP_Q_PAR: c_d = row_a_q[0];
      OP_Q_FIN: begin
        anc_d       = c_q;
        adep_d      = dd_q;
        steps_d     = steps_sum[NODE_W] ? OUT_MAX : steps_sum[NODE_W-1:0];
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // request capture and working register updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      na_q <= node_id(node_a_i);
      nb_q <= node_id(node_b_i);
    end
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; da_q <= da_d; diff_q <= diff_d;
    anc_q <= anc_d; adep_q <= adep_d; steps_q <= steps_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      hi_q        <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_q         <= x_d;
      hi_q        <= hi_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.x_last   = (32'(x_q) == MAX_NODES);
  assign sts_o.x_ge_hi  = (x_q >= hi_q);
  assign sts_o.hi_zero  = (hi_q == '0);
  assign sts_o.lvl_last = (32'(lvl_q) == LEVELS - 1);
  assign sts_o.lvl_zero = (lvl_q == '0);
  assign sts_o.a_eq_b   = (a_q == b_q);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign ancestor_o       = anc_q;
  assign ancestor_depth_o = adep_q;
  assign step_count_o     = steps_q;

endmodule

// ===== rtl/lca_binary_lifting_engine.sv =====
`timescale 1ns / 1ps
// Lowest common ancestor engine, binary lifting over a 1023-node tree.
// Input channel (in_valid_i/in_ready_o) takes one request at a time:
//   clear (empties tables), load (child node_a, parent node_b),
//   build (ancestor table and depths), query (node_a, node_b).
// Output channel (out_valid_o/out_ready_i) returns one result per query:
//   ancestor, its depth and the step count. Other requests return nothing.
// Request timing follows the table reads of the sequencer: a query runs setup,
// a lift over every level, a joint climb over every level when the lifted
// nodes differ, and a finish; build time grows with H, the highest loaded
// node id.
// Reset and clear both run a sweep over every table entry, with in_ready_o
// low, before the next request is taken.
// The result sits in an output register; a new request is accepted while it
// waits, and a following query holds in its last step until the receiver
// takes the earlier result.
module lca_binary_lifting_engine import lca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NODE_W-1:0] ancestor_o,
  output logic [NODE_W-1:0] ancestor_depth_o,
  output logic [NODE_W-1:0] step_count_o
);

  lca_cmd_t cmd;
  lca_sts_t sts;

  lca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lca_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ancestor_o       (ancestor_o),
    .ancestor_depth_o (ancestor_depth_o),
    .step_count_o     (step_count_o)
  );

endmodule

// ===== rtl/lca_checker.sv =====
`timescale 1ns / 1ps
module lca_checker import lca_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [NODE_W-1:0] ancestor_o,
  input logic [NODE_W-1:0] ancestor_depth_o,
  input logic [NODE_W-1:0] step_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ancestor_o)
      && $stable(step_count_o))
    else $error("result changed while stalled");

  // one request in flight: no accept in the cycle after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back accept");

  // node 0 sits at depth zero
  a_null_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ancestor_o == '0) |-> ancestor_depth_o == '0)
    else $error("null ancestor with nonzero depth");

  // a result appears only at the end of a query, never while idle
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a query in flight");

endmodule

bind lca_binary_lifting_engine lca_checker u_lca_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .ancestor_o       (ancestor_o),
  .ancestor_depth_o (ancestor_depth_o),
  .step_count_o     (step_count_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned RANDOM_ITEMS = 1450;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic [NODE_W-1:0] node_a_i;
  logic [NODE_W-1:0] node_b_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [NODE_W-1:0] ancestor_o;
  logic [NODE_W-1:0] ancestor_depth_o;
  logic [NODE_W-1:0] step_count_o;

  lca_binary_lifting_engine uut (.*);

  typedef struct packed {
    logic [NODE_W-1:0] anc;
    logic [NODE_W-1:0] dep;
    logic [NODE_W-1:0] steps;
  } lca_answer_t;

  typedef struct {
    req_e              kind;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    lca_answer_t       ans;
  } req_row_t;

  // shadow copy of the tree tables
  logic [NODE_W-1:0] anc_tab [0:NODES-1][0:LEVELS-1];
  logic [NODE_W-1:0] depth_of [0:NODES-1];
  int unsigned       top_node;

  lca_answer_t answer_q[$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  bit          no_idle;
  int unsigned items_sent;
  req_row_t    directed[];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_tree();
    for (int x = 0; x < NODES; x++) begin
      depth_of[x] = '0;
      for (int j = 0; j < LEVELS; j++) anc_tab[x][j] = '0;
    end
    top_node = 0;
  endfunction

  function automatic void build_tree();
    int unsigned d;
    int unsigned y;
    for (int j = 1; j < LEVELS; j++)
      for (int x = 1; x <= top_node; x++)
        anc_tab[x][j] = anc_tab[anc_tab[x][j-1]][j-1];
    for (int x = 1; x <= top_node; x++) begin
      d = 0;
      y = x;
      for (int k = LEVELS - 1; k >= 0; k--) begin
        if (anc_tab[y][k] != 0) begin
          d += 1 << k;
          y = anc_tab[y][k];
        end
      end
      depth_of[x] = (d > 1023) ? NODE_W'(1023) : NODE_W'(d);
    end
  endfunction

  function automatic lca_answer_t lca_answer(logic [NODE_W-1:0] qa, logic [NODE_W-1:0] qb);
    logic [NODE_W-1:0] x, y, c, diff;
    int unsigned       steps;
    lca_answer_t       r;
    x = qa;
    y = qb;
    if (depth_of[x] < depth_of[y]) begin
      x = qb;
      y = qa;
    end
    diff = depth_of[x] - depth_of[y];
    for (int i = 0; i < LEVELS; i++)
      if (diff[i]) x = anc_tab[x][i];
    if (x == y) begin
      c = x;
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (anc_tab[x][i] != anc_tab[y][i]) begin
          x = anc_tab[x][i];
          y = anc_tab[y][i];
        end
      end
      c = anc_tab[x][0];
    end
    steps = (depth_of[qa] > depth_of[c]) ? depth_of[qa] - depth_of[c] : 0;
    if (c != qb) steps++;
    if (steps > 1023) steps = 1023;
    r.anc = c;
    r.dep = depth_of[c];
    r.steps = NODE_W'(steps);
    return r;
  endfunction

  // update the shadow tables for one accepted request
  function automatic void track_request(req_e kind, logic [NODE_W-1:0] a,
                                        logic [NODE_W-1:0] b, bit typed, lca_answer_t ans);
    case (kind)
      REQ_CLEAR: clear_tree();
      REQ_LOAD: begin
        if (a != 0) begin
          anc_tab[a][0] = b;
          if (a > top_node) top_node = a;
          if (b > top_node) top_node = b;
        end
      end
      REQ_BUILD: build_tree();
      default: answer_q.push_back(typed ? ans : lca_answer(a, b));
    endcase
  endfunction

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(99) < 35);
  endfunction

  task automatic send(req_e kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                      bit typed = 0, lca_answer_t ans = '0);
    @(negedge clk_i);
    while (idle_roll()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = kind;
    node_a_i   = a;
    node_b_i   = b;
    do @(posedge clk_i); while (!in_ready_o);
    track_request(kind, a, b, typed, ans);
    items_sent++;
  endtask

  // one tree: clear, loads, build, then queries mixed with loads; some trees are malformed
  task automatic run_tree(bit wide);
    int unsigned       n, nq;
    bit                noisy;
    logic [NODE_W-1:0] ids[$];
    logic [NODE_W-1:0] p;
    n = wide ? $urandom_range(60, 120) : $urandom_range(3, 30);
    noisy = ($urandom_range(9) == 0);
    ids = {};
    for (int i = 0; i < n; i++)
      ids.push_back(wide ? NODE_W'($urandom_range(1, 1023)) : NODE_W'(i + 1));
    if (wide) ids[0] = NODE_W'(1023);
    send(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
    for (int i = 0; i < n; i++) begin
      p = (i == 0) ? '0 : ids[$urandom_range(i - 1)];
      if (noisy) p = ids[$urandom_range(n - 1)];
      send(REQ_LOAD, ids[i], p);
    end
    send(REQ_BUILD, NODE_W'($urandom), NODE_W'($urandom));
    nq = $urandom_range(10, 40);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(9))
        0: send(REQ_QUERY, NODE_W'($urandom), NODE_W'($urandom));
        1: send(REQ_LOAD, ids[$urandom_range(n - 1)], ids[$urandom_range(n - 1)]);
        2: send(REQ_LOAD, '0, NODE_W'($urandom));
        default: send(REQ_QUERY, ids[$urandom_range(n - 1)], ids[$urandom_range(n - 1)]);
      endcase
    end
  endtask

  // stimulus
  initial begin
    int unsigned wide_left;
    int unsigned trees;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_CLEAR;
    node_a_i    = '0;
    node_b_i    = '0;
    mismatches  = 0;
    cycle_cnt   = 0;
    items_sent  = 0;
    no_idle     = 0;
    clear_tree();
    directed = '{
      '{REQ_QUERY, 10'd0,    10'd0,    1, '{10'd0, 10'd0, 10'd0}},
      '{REQ_QUERY, 10'd1023, 10'd5,    1, '{10'd0, 10'd0, 10'd1}},
      '{REQ_LOAD,  10'd1,    10'd0,    0, '0},
      '{REQ_LOAD,  10'd2,    10'd1,    0, '0},
      '{REQ_LOAD,  10'd3,    10'd1,    0, '0},
      '{REQ_LOAD,  10'd4,    10'd2,    0, '0},
      '{REQ_LOAD,  10'd5,    10'd4,    0, '0},
      '{REQ_LOAD,  10'd0,    10'd7,    0, '0},
      '{REQ_QUERY, 10'd5,    10'd3,    0, '0},
      '{REQ_BUILD, 10'd0,    10'd0,    0, '0},
      '{REQ_QUERY, 10'd5,    10'd3,    0, '0},
      '{REQ_QUERY, 10'd3,    10'd5,    0, '0},
      '{REQ_QUERY, 10'd5,    10'd5,    0, '0},
      '{REQ_QUERY, 10'd1,    10'd5,    0, '0},
      '{REQ_QUERY, 10'd5,    10'd1023, 0, '0},
      '{REQ_LOAD,  10'd3,    10'd5,    0, '0},
      '{REQ_QUERY, 10'd3,    10'd2,    0, '0},
      '{REQ_LOAD,  10'd1,    10'd3,    0, '0},
      '{REQ_BUILD, 10'd1023, 10'd1023, 0, '0},
      '{REQ_QUERY, 10'd3,    10'd4,    0, '0},
      '{REQ_QUERY, 10'd2,    10'd0,    0, '0},
      '{REQ_CLEAR, 10'd1023, 10'd1023, 0, '0},
      '{REQ_QUERY, 10'd4,    10'd2,    1, '{10'd0, 10'd0, 10'd1}}
    };
    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i])
      send(directed[i].kind, directed[i].a, directed[i].b, directed[i].typed, directed[i].ans);
    wide_left = 3;
    trees = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (trees == 4);
      if (trees == 7) begin
        // drop valid and hold off until the result queue drains
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait (answer_q.size() == 0);
      end
      if (wide_left > 0 && (trees % 10 == 2)) begin
        run_tree(1);
        wide_left--;
      end else begin
        run_tree(0);
      end
      trees++;
    end
    no_idle = 0;
    send(REQ_QUERY, NODE_W'($urandom), NODE_W'($urandom));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (answer_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stalls, compare at the accepting edge
  initial begin
    lca_answer_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result anc=%0d dep=%0d steps=%0d",
                     ancestor_o, ancestor_depth_o, step_count_o);
        end else begin
          want = answer_q.pop_front();
          if (want.anc !== ancestor_o || want.dep !== ancestor_depth_o ||
              want.steps !== step_count_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected anc=%0d dep=%0d steps=%0d, got %0d %0d %0d",
                       want.anc, want.dep, want.steps,
                       ancestor_o, ancestor_depth_o, step_count_o);
          end
        end
      end
      @(negedge clk_i);
      out_ready_i = !idle_roll();
    end
  end

endmodule
